// ----- rtl/sm4_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the SM4 block cipher.
// Used by the controller, the datapath, the top level and the checker.
package sm4_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int RND_W       = $clog2(ROUND_COUNT);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  localparam logic        FUNC_ENCRYPT = 1'b0;
  localparam logic        FUNC_DECRYPT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } sm4_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_out_t;

  typedef enum logic [2:0] {
    ST_KLOAD,
    ST_KEY,
    ST_IDLE,
    ST_CRYPT,
    ST_DONE
  } sm4_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic             key_load;   // load words from key ^ FK
    logic             blk_load;   // load words from input block
    logic             step;       // run one round on the words
    logic             key_mode;   // key schedule round, store round key
    logic [RND_W-1:0] rnd;        // round number
    logic             out_load;   // capture result into output register
  } sm4_cmd_t;

  localparam logic [31:0] FK [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sub_bytes(input logic [31:0] v);
    logic [31:0] r;
    for (int j = 0; j < 4; j++) begin
      r[j*8 +: 8] = SBOX[v[j*8 +: 8]];
    end
    return r;
  endfunction

  // CK byte j of word i is (4*i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
    logic [31:0] w;
    logic [7:0]  n;
    for (int j = 0; j < 4; j++) begin
      n = {1'b0, i, 2'(j)};
      w[(3-j)*8 +: 8] = 8'(n * 8'd7);
    end
    return w;
  endfunction

endpackage

// ----- rtl/sm4_block_cipher.sv -----
`timescale 1ns / 1ps
// SM4 block cipher top level: controller plus datapath.
// Depends on sm4_pkg, sm4_ctrl and sm4_dp.
//
// Usage:
//   cfg_*  : key write port. Index 0 is key bits 127..64, index 1 bits 63..0.
//            A write is taken when cfg_valid and cfg_ready are high; it
//            starts a key schedule (a load step, then the 32 key rounds).
//   in_*   : one transaction carries func (0 encrypt, 1 decrypt) and a
//            128-bit block. Taken when in_valid is high and in_stall low.
//   out_*  : one result per input, held in an output register.
// Flow: a block is loaded, runs 32 rounds on the shared round unit, then is
// captured into the output register. A new block is taken only after the
// last one is captured; the round unit handles one round per cycle.
// Reset: synchronous, rst_n low. The key is cleared and the round keys of
// the all-zero key are rebuilt (meanwhile in_stall is high, cfg_ready low).
// Back-pressure: while out_stall holds a result, the next block may still
// be taken and run; it waits after its last round until the register frees.
module sm4_block_cipher
  import sm4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sm4_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sm4_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  sm4_cmd_t cmd;

  sm4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  sm4_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .key_wr   (cfg_valid && cfg_ready),
    .key_idx  (cfg_index),
    .key_data (cfg_data),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- rtl/sm4_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the SM4 block: key schedule after reset or a key write,
// 32 cipher rounds per block, and the output register handshake. Uses sm4_pkg.
module sm4_ctrl
  import sm4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output sm4_cmd_t cmd
);

  sm4_state_t       state_r, state_nxt;
  logic [RND_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_rnd;
  logic             cfg_wr;
  logic             in_acc;
  logic             out_free;

  assign last_rnd = (cnt_r == RND_W'(ROUND_COUNT - 1));
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;
  // a pending key write wins over a new block
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_KLOAD: state_nxt = ST_KEY;
      ST_KEY:   if (last_rnd) begin
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_wr) begin
          state_nxt = ST_KLOAD;
        end else if (in_acc) begin
          state_nxt = ST_CRYPT;
        end
      end
      ST_CRYPT: if (last_rnd) begin
        state_nxt = ST_DONE;
      end
      ST_DONE:  if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.rnd       = cnt_r;
    cnt_nxt       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_KLOAD: cmd.key_load = 1'b1;
      ST_KEY: begin
        cmd.step     = 1'b1;
        cmd.key_mode = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      ST_IDLE:  cmd.blk_load = in_acc;
      ST_CRYPT: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = out_free;
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KLOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/sm4_dp.sv -----
`timescale 1ns / 1ps
// SM4 datapath: key registers, 4-word round state, one shared round unit,
// round key store and output register. Uses sm4_pkg.
module sm4_dp
  import sm4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sm4_cmd_t             cmd,
  input  logic                 key_wr,
  input  logic [CFG_IDX_W-1:0] key_idx,
  input  logic [63:0]          key_data,
  input  sm4_in_t              in_data,
  output sm4_out_t             out_data
);

  logic [63:0]      key_hi_r, key_hi_nxt;
  logic [63:0]      key_lo_r, key_lo_nxt;
  logic [31:0]      w_r [4];
  logic [31:0]      w_nxt [4];
  logic             dec_r;
  logic [31:0]      rk_r [ROUND_COUNT];
  logic [31:0]      rk_q_r;
  sm4_out_t         res_r;
  logic [RND_W-1:0] rd_rnd;
  logic             rd_dec;
  logic [RND_W-1:0] rk_addr;
  logic [31:0]      mix_in, sb, lin, new_w;

  always_comb begin
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    if (key_wr) begin
      case (key_idx)
        REG_KEY_HIGH: key_hi_nxt = key_data;
        REG_KEY_LOW:  key_lo_nxt = key_data;
        default: ;
      endcase
    end
  end

  // round key is registered from the store in the cycle before the round that
  // uses it; decrypt walks the round keys backwards
  assign rd_rnd  = cmd.blk_load ? '0 : cmd.rnd + 1'b1;
  assign rd_dec  = cmd.blk_load ? in_data.func : dec_r;
  assign rk_addr = (rd_dec == FUNC_DECRYPT) ? ~rd_rnd : rd_rnd;
  assign mix_in  = w_r[1] ^ w_r[2] ^ w_r[3] ^ (cmd.key_mode ? ck_word(cmd.rnd) : rk_q_r);
  assign sb      = sub_bytes(mix_in);
  assign lin     = cmd.key_mode
                 ? (sb ^ {sb[18:0], sb[31:19]} ^ {sb[8:0], sb[31:9]})
                 : (sb ^ {sb[29:0], sb[31:30]} ^ {sb[21:0], sb[31:22]}
                       ^ {sb[13:0], sb[31:14]} ^ {sb[7:0], sb[31:8]});
  assign new_w   = w_r[0] ^ lin;

  always_comb begin
    w_nxt = w_r;
    if (cmd.key_load) begin
      w_nxt[0] = key_hi_r[63:32] ^ FK[0];
      w_nxt[1] = key_hi_r[31:0]  ^ FK[1];
      w_nxt[2] = key_lo_r[63:32] ^ FK[2];
      w_nxt[3] = key_lo_r[31:0]  ^ FK[3];
    end else if (cmd.blk_load) begin
      w_nxt[0] = in_data.block_high[63:32];
      w_nxt[1] = in_data.block_high[31:0];
      w_nxt[2] = in_data.block_low[63:32];
      w_nxt[3] = in_data.block_low[31:0];
    end else if (cmd.step) begin
      w_nxt[0] = w_r[1];
      w_nxt[1] = w_r[2];
      w_nxt[2] = w_r[3];
      w_nxt[3] = new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else begin
      key_hi_r <= key_hi_nxt;
      key_lo_r <= key_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (cmd.blk_load) begin
      dec_r <= in_data.func;
    end
    if (cmd.step && cmd.key_mode) begin
      rk_r[cmd.rnd] <= new_w;
    end
    rk_q_r <= rk_r[rk_addr];
    if (cmd.out_load) begin
      res_r.result_high <= {w_r[3], w_r[2]};
      res_r.result_low  <= {w_r[1], w_r[0]};
    end
  end

  assign out_data = res_r;

endmodule

// ----- rtl/sm4_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for sm4_block_cipher, attached by bind.
// Uses sm4_pkg for the payload types.
module sm4_chk
  import sm4_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sm4_out_t out_data,
  input logic     cfg_valid,
  input logic     cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // a block in flight blocks both new blocks and key writes
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("not busy after input transaction");

  // key schedule must block input right after a key write
  a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall && !cfg_ready)
    else $error("not busy after key write");

endmodule

bind sm4_block_cipher sm4_chk u_sm4_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
